FILE: rtl/core/itrq_pkg.sv
// Package for the ID-tagged ring queue: sizes, operation and status codes,
// and the structs passed between the core's modules. No dependencies.
`timescale 1ns / 1ps

package itrq_pkg;

    localparam int CAPACITY   = 64;
    localparam int DATA_WIDTH = 32;
    localparam int ID_WIDTH   = 48;
    localparam int SLOT_W     = $clog2(CAPACITY);
    localparam int CNT_W      = SLOT_W + 1;

    typedef logic [1:0]            t_func;
    typedef logic [2:0]            t_status;
    typedef logic [DATA_WIDTH-1:0] t_data;
    typedef logic [ID_WIDTH-1:0]   t_id;
    typedef logic [SLOT_W-1:0]     t_slot;
    typedef logic [CNT_W-1:0]      t_cnt;

    localparam t_func FUNC_ENQ = 2'd0;
    localparam t_func FUNC_DEQ = 2'd1;
    localparam t_func FUNC_RD  = 2'd2;

    localparam t_status ST_OK        = 3'd0;
    localparam t_status ST_FULL      = 3'd1;
    localparam t_status ST_EMPTY     = 3'd2;
    localparam t_status ST_BAD_ID    = 3'd3;
    localparam t_status ST_EXHAUSTED = 3'd4;

    // Per-operation outcome, minus the read word (that comes from the store).
    typedef struct packed {
        t_status status;
        t_id     assigned_id;
        t_id     front_id;
        t_id     back_id;
        t_cnt    entry_count;
        logic    is_full;
        logic    is_empty;
        logic    rd_hit;
    } t_res;

    // Slot store access for one operation.
    typedef struct packed {
        logic  wr_en;
        t_slot wr_addr;
        t_data wr_data;
        logic  rd_en;
        t_slot rd_addr;
    } t_mem_req;

    // Full result as delivered on the output channel.
    typedef struct packed {
        t_status status;
        t_id     assigned_id;
        t_data   read_data;
        t_id     front_id;
        t_id     back_id;
        t_cnt    entry_count;
        logic    is_full;
        logic    is_empty;
    } t_rsp;

endpackage

FILE: rtl/core/itrq_if.sv
// Valid/ready channel interfaces for the ring queue: request and response.
// Depends on itrq_pkg.
`timescale 1ns / 1ps

interface itrq_req_if;
    logic             valid;
    logic             ready;
    itrq_pkg::t_func  func;
    itrq_pkg::t_data  data_in;
    itrq_pkg::t_id    req_id;

    modport source (output valid, output func, output data_in, output req_id, input ready);
    modport sink   (input valid, input func, input data_in, input req_id, output ready);
endinterface

interface itrq_rsp_if;
    logic              valid;
    logic              ready;
    itrq_pkg::t_status status;
    itrq_pkg::t_id     assigned_id;
    itrq_pkg::t_data   read_data;
    itrq_pkg::t_id     front_id;
    itrq_pkg::t_id     back_id;
    itrq_pkg::t_cnt    entry_count;
    logic              is_full;
    logic              is_empty;

    modport source (
        output valid, output status, output assigned_id, output read_data,
        output front_id, output back_id, output entry_count, output is_full,
        output is_empty, input ready
    );
    modport sink (
        input valid, input status, input assigned_id, input read_data,
        input front_id, input back_id, input entry_count, input is_full,
        input is_empty, output ready
    );
endinterface

FILE: rtl/core/itrq_ctrl.sv
// Head/tail pointers and the per-operation decision logic of the ring queue.
// Depends on itrq_pkg.
`timescale 1ns / 1ps

module itrq_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  itrq_pkg::t_func    i_func,
    input  itrq_pkg::t_data    i_data_in,
    input  itrq_pkg::t_id      i_req_id,
    output itrq_pkg::t_res     o_res,
    output itrq_pkg::t_mem_req o_mem
);
    import itrq_pkg::*;

    t_id     r_head, r_tail;
    t_id     n_head, n_tail;
    t_id     diff, n_diff;
    t_cnt    cnt;
    logic    full, empty, at_top, in_q, n_empty;
    t_status status;
    logic    wr_en, rd_hit;

    assign diff   = r_head - r_tail;
    assign cnt    = diff[CNT_W-1:0];
    assign full   = (cnt == CNT_W'(CAPACITY));
    assign empty  = (r_head == r_tail);
    assign at_top = (r_head == '1);
    assign in_q   = (i_req_id >= r_tail) && (i_req_id < r_head);

    always_comb begin
        n_head = r_head;
        n_tail = r_tail;
        status = ST_BAD_ID;
        wr_en  = 1'b0;
        rd_hit = 1'b0;
        case (i_func)
            FUNC_ENQ: begin
                if (full) begin
                    status = ST_FULL;
                end else if (at_top) begin
                    status = ST_EXHAUSTED;
                end else begin
                    status = ST_OK;
                    wr_en  = 1'b1;
                    n_head = r_head + 1'b1;
                end
            end
            FUNC_DEQ: begin
                if (empty) begin
                    status = ST_EMPTY;
                end else if (i_req_id == r_tail) begin
                    status = ST_OK;
                    n_tail = r_tail + 1'b1;
                end
            end
            FUNC_RD: begin
                if (in_q) begin
                    status = ST_OK;
                    rd_hit = 1'b1;
                end
            end
            default: begin
                status = ST_BAD_ID;
            end
        endcase
    end

    // queue view after the operation
    assign n_diff  = n_head - n_tail;
    assign n_empty = (n_head == n_tail);

    always_comb begin
        o_res.status      = status;
        o_res.assigned_id = wr_en ? r_head : '0;
        o_res.front_id    = n_empty ? '0 : n_head - 1'b1;
        o_res.back_id     = n_empty ? '0 : n_tail;
        o_res.entry_count = n_diff[CNT_W-1:0];
        o_res.is_full     = (n_diff[CNT_W-1:0] == CNT_W'(CAPACITY));
        o_res.is_empty    = n_empty;
        o_res.rd_hit      = rd_hit;
    end

    always_comb begin
        o_mem.wr_en   = i_accept && wr_en;
        o_mem.wr_addr = r_head[SLOT_W-1:0];
        o_mem.wr_data = i_data_in;
        o_mem.rd_en   = i_accept && rd_hit;
        o_mem.rd_addr = i_req_id[SLOT_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_tail <= '0;
        end else if (i_accept) begin
            r_head <= n_head;
            r_tail <= n_tail;
        end
    end

endmodule

FILE: rtl/core/itrq_store.sv
// Slot store: CAPACITY data words, one write and one registered read port.
// Depends on itrq_pkg.
`timescale 1ns / 1ps

module itrq_store (
    input  logic               i_clk,
    input  itrq_pkg::t_mem_req i_mem,
    output itrq_pkg::t_data    o_rd_data
);
    import itrq_pkg::*;

    t_data r_mem [CAPACITY];
    t_data r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_mem.wr_en) begin
            r_mem[i_mem.wr_addr] <= i_mem.wr_data;
        end
    end

    // read register holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_mem.rd_en) begin
            r_rd_data <= r_mem[i_mem.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/core/itrq_skid.sv
// Output register with skid entry for response transfers; ready is registered.
// Depends on itrq_pkg.
`timescale 1ns / 1ps

module itrq_skid (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  itrq_pkg::t_rsp i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output itrq_pkg::t_rsp o_data
);
    import itrq_pkg::*;

    logic r_out_vld, r_skd_vld;
    t_rsp r_out, r_skd;
    logic in_fire, out_free;

    assign o_ready  = !r_skd_vld;
    assign in_fire  = i_valid && !r_skd_vld;
    assign out_free = !r_out_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_skd_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_skd_vld || in_fire;
            r_skd_vld <= 1'b0;
        end else if (in_fire) begin
            r_skd_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skd_vld ? r_skd : i_data;
        end else if (in_fire) begin
            r_skd <= i_data;
        end
    end

    assign o_valid = r_out_vld;
    assign o_data  = r_out;

endmodule

FILE: rtl/core/id_tagged_ring_queue_core.sv
// ID-tagged ring queue core: top level tying pointers, slot store and output buffer.
// Depends on itrq_pkg, itrq_if, itrq_ctrl, itrq_store, itrq_skid.
`timescale 1ns / 1ps

// One operation per transfer on i_req (enqueue, dequeue by ID, read by ID);
// one response per operation on o_rsp, in order. Throughput is one operation
// per clock unless responses back up: pointer compares are combinational and
// each operation makes at most one slot-store access, served by the store's
// one write port plus one registered read port. The operation is decided and
// its result and read word registered at the accepting edge, then passed to
// the output register, or to the skid entry while the output stalls. The skid
// entry behind the output register keeps i_req.ready registered, so a stalled
// response costs no input cycle until both output entries fill. IDs are 48
// bits and never wrap: once the head ID reaches all ones, enqueue answers "ID
// space exhausted". Reset clears the pointers and valid flags only; the slot
// store needs no clearing because a slot is only read after it is written.
module id_tagged_ring_queue_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    itrq_req_if.sink          i_req,
    itrq_rsp_if.source        o_rsp
);
    import itrq_pkg::*;

    t_res     res;
    t_mem_req mem;
    t_data    rd_data;
    t_rsp     stg_rsp, out_rsp;
    logic     accept, stg_adv, skid_ready;

    logic     r_vld;
    t_res     r_res;

    // stage moves on when empty or when the buffer takes its result
    assign stg_adv     = !r_vld || skid_ready;
    assign i_req.ready = stg_adv;
    assign accept      = i_req.valid && stg_adv;

    itrq_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_func    (i_req.func),
        .i_data_in (i_req.data_in),
        .i_req_id  (i_req.req_id),
        .o_res     (res),
        .o_mem     (mem)
    );

    // read word lands in the store's read register alongside r_res
    itrq_store u_store (
        .i_clk     (i_clk),
        .i_mem     (mem),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= accept || (r_vld && !skid_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= res;
        end
    end

    always_comb begin
        stg_rsp.status      = r_res.status;
        stg_rsp.assigned_id = r_res.assigned_id;
        stg_rsp.read_data   = r_res.rd_hit ? rd_data : '0;
        stg_rsp.front_id    = r_res.front_id;
        stg_rsp.back_id     = r_res.back_id;
        stg_rsp.entry_count = r_res.entry_count;
        stg_rsp.is_full     = r_res.is_full;
        stg_rsp.is_empty    = r_res.is_empty;
    end

    itrq_skid u_skid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_vld),
        .o_ready (skid_ready),
        .i_data  (stg_rsp),
        .o_valid (o_rsp.valid),
        .i_ready (o_rsp.ready),
        .o_data  (out_rsp)
    );

    assign o_rsp.status      = out_rsp.status;
    assign o_rsp.assigned_id = out_rsp.assigned_id;
    assign o_rsp.read_data   = out_rsp.read_data;
    assign o_rsp.front_id    = out_rsp.front_id;
    assign o_rsp.back_id     = out_rsp.back_id;
    assign o_rsp.entry_count = out_rsp.entry_count;
    assign o_rsp.is_full     = out_rsp.is_full;
    assign o_rsp.is_empty    = out_rsp.is_empty;

endmodule

FILE: tb/sv/id_tagged_ring_queue_core_tb.sv
// Testbench for id_tagged_ring_queue_core: random and directed queue operations,
// checked against a shadow of the queue. Depends on itrq_pkg, itrq_if and the core.
`timescale 1ns / 1ps

module id_tagged_ring_queue_core_tb;

    import itrq_pkg::*;

    // Func 3 has no name in the package; the core must answer it as a bad ID.
    localparam t_func       FUNC_UNUSED = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 500_000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned MAX_SHOWN   = 40;

    // Shadow of the queue. apply_op predicts the response of one accepted
    // operation and queues it; check_rsp compares a delivered response with
    // the oldest prediction.
    class queue_shadow;
        t_id         head_id;
        t_id         tail_id;
        t_data       slot_word [CAPACITY];
        t_rsp        rsp_due [$];
        int unsigned errors;
        int unsigned checked;
        int unsigned status_hits [5];

        function new();
            head_id = '0;
            tail_id = '0;
            errors  = 0;
            checked = 0;
            foreach (slot_word[i]) slot_word[i] = '0;
            foreach (status_hits[i]) status_hits[i] = 0;
        endfunction

        function int unsigned outstanding();
            return rsp_due.size();
        endfunction

        function void apply_op(t_func f, t_data d, t_id id);
            t_rsp r;
            t_id  used;
            r        = '0;
            r.status = ST_BAD_ID;
            case (f)
                FUNC_ENQ: begin
                    if (head_id - tail_id == t_id'(CAPACITY)) begin
                        r.status = ST_FULL;
                    end else if (head_id == '1) begin
                        r.status = ST_EXHAUSTED;
                    end else begin
                        slot_word[head_id[SLOT_W-1:0]] = d;
                        r.assigned_id = head_id;
                        head_id       = head_id + 1'b1;
                        r.status      = ST_OK;
                    end
                end
                FUNC_DEQ: begin
                    if (head_id == tail_id) begin
                        r.status = ST_EMPTY;
                    end else if (id == tail_id) begin
                        tail_id  = tail_id + 1'b1;
                        r.status = ST_OK;
                    end
                end
                FUNC_RD: begin
                    if (tail_id <= id && id < head_id) begin
                        r.read_data = slot_word[id[SLOT_W-1:0]];
                        r.status    = ST_OK;
                    end
                end
                default: ;
            endcase
            used          = head_id - tail_id;
            r.entry_count = used[CNT_W-1:0];
            r.is_empty    = (head_id == tail_id);
            r.is_full     = (used == t_id'(CAPACITY));
            r.front_id    = r.is_empty ? '0 : head_id - 1'b1;
            r.back_id     = r.is_empty ? '0 : tail_id;
            if (r.status <= ST_EXHAUSTED) status_hits[r.status]++;
            rsp_due.push_back(r);
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            if (errors <= MAX_SHOWN)
                $display("[%0t] mismatch on response %0d: %s got %0h expected %0h",
                         $time, checked, what, got, want);
        endtask

        task check_rsp(t_rsp got);
            t_rsp want;
            if (rsp_due.size() == 0) begin
                report("unexpected response, status", got.status, 0);
                return;
            end
            want = rsp_due.pop_front();
            if (got.status != want.status)
                report("status", got.status, want.status);
            if (got.assigned_id != want.assigned_id)
                report("assigned_id", got.assigned_id, want.assigned_id);
            if (got.read_data != want.read_data)
                report("read_data", got.read_data, want.read_data);
            if (got.front_id != want.front_id)
                report("front_id", got.front_id, want.front_id);
            if (got.back_id != want.back_id)
                report("back_id", got.back_id, want.back_id);
            if (got.entry_count != want.entry_count)
                report("entry_count", got.entry_count, want.entry_count);
            if (got.is_full != want.is_full)
                report("is_full", got.is_full, want.is_full);
            if (got.is_empty != want.is_empty)
                report("is_empty", got.is_empty, want.is_empty);
            checked++;
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    itrq_req_if req_if ();
    itrq_rsp_if rsp_if ();

    id_tagged_ring_queue_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    // 12 ns period
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    queue_shadow sb = new();

    int unsigned cycle_cnt = 0;
    int unsigned n_sent    = 0;
    int unsigned hold_left = 0;   // receiver hold-off, counts down below
    bit          req_idle  = 1'b1;
    bit          rsp_idle  = 1'b1;

    // Watchdog: any hang or lost response ends the run here.
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d responses outstanding",
                     cycle_cnt, sb.outstanding());
            $display("status: fail");
            $finish;
        end
    end

    // Long receiver hold-off, counted here so it runs whether or not a
    // response is pending. Written with NBAs so every reader sees the
    // pre-edge count.
    always @(posedge i_clk) begin
        if (hold_left != 0) hold_left <= hold_left - 1;
    end

    function automatic int unsigned idle_gap(bit on);
        return on ? $urandom_range(0, 15) : 0;
    endfunction

    // One transfer on the request channel. valid stays high across
    // back-to-back transfers; a gap drops it first. The shadow is updated
    // at the accepting edge so the next pick sees the current pointers.
    task automatic send_op(t_func f, t_data d, t_id id, int unsigned gap);
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.func    <= f;
        req_if.data_in <= d;
        req_if.req_id  <= id;
        do @(posedge i_clk); while (!req_if.ready);
        sb.apply_op(f, d, id);
        n_sent++;
    endtask

    // Response side: random stall per response, plus the long hold-off when
    // one is running. ready gets one NBA per edge at most.
    task automatic take_responses();
        int unsigned stall;
        t_rsp        got;
        forever begin
            stall = idle_gap(rsp_idle);
            if (stall != 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_if.ready <= (hold_left == 0);
            forever begin
                @(posedge i_clk);
                if (rsp_if.valid && rsp_if.ready) break;
                rsp_if.ready <= (hold_left == 0);
            end
            got.status      = rsp_if.status;
            got.assigned_id = rsp_if.assigned_id;
            got.read_data   = rsp_if.read_data;
            got.front_id    = rsp_if.front_id;
            got.back_id     = rsp_if.back_id;
            got.entry_count = rsp_if.entry_count;
            got.is_full     = rsp_if.is_full;
            got.is_empty    = rsp_if.is_empty;
            sb.check_rsp(got);
        end
    endtask

    // Wait for every predicted response to come back.
    task automatic drain();
        while (sb.outstanding() != 0) @(posedge i_clk);
    endtask

    // Random operation, mostly well-formed: dequeues aim at the tail ID and
    // reads at live IDs; the rest hit the ID after the tail, just outside the
    // live window or a fully random 48-bit ID so every ID bit toggles.
    function automatic void pick_op(int unsigned enq_pct, output t_func f,
                                    output t_data d, output t_id id);
        int unsigned r;
        t_id         live;
        d    = $urandom;
        id   = t_id'({$urandom, $urandom});
        live = sb.head_id - sb.tail_id;
        r    = $urandom_range(0, 99);
        if (r < enq_pct) begin
            f = FUNC_ENQ;
        end else begin
            f = $urandom_range(0, 1) ? FUNC_DEQ : FUNC_RD;
            r = $urandom_range(0, 99);
            if (f == FUNC_DEQ) begin
                if (r < 85)      id = sb.tail_id;
                else if (r < 92) id = sb.tail_id + 1'b1;
            end else begin
                if (r < 75 && live != 0)
                    id = sb.tail_id + t_id'($urandom_range(0, int'(live) - 1));
                else if (r < 85) id = sb.head_id;
                else if (r < 92) id = sb.tail_id - 1'b1;
            end
        end
    endfunction

    initial begin
        t_func       f;
        t_data       d;
        t_id         id;
        int unsigned enq_pct;

        // Every input known from time zero.
        i_rst_n        <= 1'b0;
        req_if.valid   <= 1'b0;
        req_if.func    <= FUNC_ENQ;
        req_if.data_in <= '0;
        req_if.req_id  <= '0;
        rsp_if.ready   <= 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        fork
            take_responses();
        join_none

        // Directed: empty-queue errors, the unused func code, data extremes,
        // reads inside and outside the live window, wrong-ID dequeues.
        send_op(FUNC_RD,     '0, '0, idle_gap(1));   // read on empty
        send_op(FUNC_DEQ,    '0, '0, idle_gap(1));   // dequeue on empty
        send_op(FUNC_UNUSED, '1, '0, idle_gap(1));
        send_op(FUNC_ENQ,    '0, '1, idle_gap(1));
        send_op(FUNC_ENQ,    '1, '0, idle_gap(1));
        send_op(FUNC_ENQ,    32'h8000_0001, '0, idle_gap(1));
        send_op(FUNC_RD,     '0, 48'd0, idle_gap(1));
        send_op(FUNC_RD,     '0, 48'd1, idle_gap(1));
        send_op(FUNC_RD,     '0, 48'd3, idle_gap(1));   // head, one past newest
        send_op(FUNC_RD,     '0, '1, idle_gap(1));
        send_op(FUNC_DEQ,    '0, 48'd1, idle_gap(1));   // not the tail
        send_op(FUNC_DEQ,    '0, '1, idle_gap(1));
        send_op(FUNC_DEQ,    '1, 48'd0, idle_gap(1));
        send_op(FUNC_RD,     '0, 48'd0, idle_gap(1));   // already dequeued
        send_op(FUNC_DEQ,    '0, 48'd1, idle_gap(1));
        send_op(FUNC_DEQ,    '0, 48'd2, idle_gap(1));
        send_op(FUNC_DEQ,    '0, 48'd3, idle_gap(1));   // empty again
        send_op(FUNC_RD,     '0, 48'd2, idle_gap(1));
        send_op(FUNC_ENQ,    32'h7FFF_FFFE, '0, idle_gap(1));
        send_op(FUNC_RD,     '0, 48'h8000_0000_0003, 0);
        send_op(FUNC_RD,     '0, 48'd3, 0);
        send_op(FUNC_UNUSED, '0, 48'd3, 0);

        // Pressure: sender pauses until all responses are in, then the
        // receiver holds off while enqueues stream back to back. The core
        // backs up into i_req, and the enqueues past 64 entries see full.
        req_if.valid <= 1'b0;
        drain();
        req_idle  = 1'b0;
        rsp_idle  = 1'b0;
        hold_left <= HOLD_CYCLES;
        repeat (80) send_op(FUNC_ENQ, $urandom, t_id'({$urandom, $urandom}), 0);
        repeat (70) send_op(FUNC_DEQ, $urandom, sb.tail_id, 0);

        // Random blocks: enqueue mix cycles between filling, balanced and
        // draining; idling toggles on each side so all four combinations,
        // including back-to-back on both sides, come up.
        for (int blk = 0; blk < 14; blk++) begin
            case (blk % 3)
                0:       enq_pct = 85;
                1:       enq_pct = 50;
                default: enq_pct = 15;
            endcase
            req_idle = blk[0];
            rsp_idle = blk[1];
            if (blk == 7) begin
                req_if.valid <= 1'b0;
                drain();
            end
            repeat (100) begin
                pick_op(enq_pct, f, d, id);
                send_op(f, d, id, idle_gap(req_idle));
            end
        end
        req_if.valid <= 1'b0;

        drain();
        repeat (10) @(posedge i_clk);

        $display("%0d operations sent, %0d responses checked in %0d cycles",
                 n_sent, sb.checked, cycle_cnt);
        $display("outcomes: ok %0d, full %0d, empty %0d, bad id %0d, mismatches %0d",
                 sb.status_hits[ST_OK], sb.status_hits[ST_FULL],
                 sb.status_hits[ST_EMPTY], sb.status_hits[ST_BAD_ID], sb.errors);
        if (sb.errors == 0 && sb.outstanding() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/itrq_pkg.sv
rtl/core/itrq_if.sv
rtl/core/itrq_ctrl.sv
rtl/core/itrq_store.sv
rtl/core/itrq_skid.sv
rtl/core/id_tagged_ring_queue_core.sv
tb/sv/id_tagged_ring_queue_core_tb.sv
